// ===== design/pidf_pkg.sv =====
package pidf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_W            = 32;
    localparam int OUT_W           = 32;
    localparam int DT_W            = 24;
    localparam int GAIN_W          = 31;
    localparam int F_W             = 32;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUM_LIMIT = 3'd4;

    // Q0.16 smoothing weights for the new and the previous derivative.
    localparam logic [15:0] EMA_NEW = 16'd45875;
    localparam logic [15:0] EMA_OLD = 16'd19661;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

endpackage

// ===== design/pidf_div.sv =====
module pidf_div #(
    parameter int W = pidf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [W:0]                  dividend_mag,
    input  logic [pidf_pkg::DT_W-1:0]   divisor,
    output pidf_pkg::div_stat_t         stat,
    output logic [W-1:0]                quotient
);
    import pidf_pkg::*;

    localparam int RW = W + DT_W + 1;
    localparam int CW = $clog2(W + 1);

    logic [RW-1:0] rem_reg;
    logic [RW-1:0] dsh_reg;
    logic [W:0]    quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DT_W-1:0] dv_safe;
    logic          ge;

    // A zero time step divides by one.
    assign dv_safe = (divisor == '0) ? DT_W'(1) : divisor;
    assign ge      = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg <= {dividend_mag, {DT_W{1'b0}}};
                dsh_reg <= RW'(dv_safe) << W;
                cnt_reg <= CW'(W);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                // The first step tests bit W; a set bit there means the
                // quotient is beyond any representable magnitude.
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quo_reg <= {quo_reg[W-1:0], ge};
                dsh_reg <= dsh_reg >> 1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.ovf  = quo_reg[W];
    assign quotient  = quo_reg[W-1:0];

endmodule

// ===== design/pid_with_filtered_derivative_core.sv =====
// PID controller with derivative on measurement, smoothed derivative and
// integral anti-windup.
//
// Configuration: write gains and limits through cfg_valid/cfg_ready with a
// register index and 31-bit data; cfg_ready is always high. Write only while
// no sample is in progress.
// Input: one sample per transfer on s_valid/s_ready. s_ready is high only
// while the sequencer is idle.
// Output: one drive value per sample on m_valid/m_ready, held in an output
// register, so the next sample can be taken while a result waits.
// Timing: one shared multiplier handles six products, each through the select,
// low-half multiply, high-half multiply, round and post steps, and a radix-2
// divider forms the derivative. When hold_accum is set the integral increment
// product is skipped. If m_ready stays low the sequencer waits in its final
// step until the output register frees up.
// Reset: synchronous, active low; clears the configuration, the integral,
// the previous measurement, the smoothed derivative and the output valid.
module pid_with_filtered_derivative_core #(
    parameter int VALUE_WIDTH = pidf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidf_pkg::GAIN_W-1:0]         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pidf_pkg::IN_W-1:0]    s_target,
    input  logic signed [pidf_pkg::IN_W-1:0]    s_sensed,
    input  logic [pidf_pkg::DT_W-1:0]           s_step_time,
    input  logic                                s_hold_accum,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pidf_pkg::OUT_W-1:0]   m_drive
);
    import pidf_pkg::*;

    localparam int W    = VALUE_WIDTH;
    localparam int XW   = W + 34;
    localparam int PW   = W + F_W;
    localparam int HALF = (W + 1) / 2;

    localparam logic signed [XW-1:0] WMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] WMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [PW:0] HALF16 = {{(PW-15){1'b0}}, 1'b1, 15'b0};
    localparam logic [PW:0] HALF24 = {{(PW-23){1'b0}}, 1'b1, 23'b0};

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIFF = 9'b000000010,
        ST_SEL  = 9'b000000100,
        ST_MLO  = 9'b000001000,
        ST_MHI  = 9'b000010000,
        ST_RND  = 9'b000100000,
        ST_POST = 9'b001000000,
        ST_DIVW = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        OP_P   = 3'd0,
        OP_INC = 3'd1,
        OP_I   = 3'd2,
        OP_NEW = 3'd3,
        OP_OLD = 3'd4,
        OP_D   = 3'd5
    } op_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] y;
        if (x > WMAX_X) begin
            y = WMAX_X;
        end else if (x < WMIN_X) begin
            y = WMIN_X;
        end else begin
            y = x;
        end
        return y[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] clamp_w(input logic signed [XW-1:0] x,
                                                    input logic [GAIN_W-1:0] lim);
        logic signed [XW-1:0] limx;
        logic signed [XW-1:0] y;
        limx = signed'({{(XW-GAIN_W){1'b0}}, lim});
        if (x > limx) begin
            y = limx;
        end else if (x < -limx) begin
            y = -limx;
        end else begin
            y = x;
        end
        return sat_w(y);
    endfunction

    state_t state_reg;
    op_t    op_reg;

    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [GAIN_W-1:0] drive_limit_reg, accum_limit_reg;

    logic signed [W-1:0] accum_reg, last_reg, smooth_reg;
    logic signed [W-1:0] t_reg, s_reg, err_reg, p_reg, raw_reg, ema_reg, r_reg;
    logic [DT_W-1:0]     dt_reg;
    logic                hold_reg;
    logic [W:0]          div_mag_reg;
    logic                div_neg_reg;
    logic signed [XW-1:0] sum_reg;
    logic [OUT_W-1:0]    drive_res_reg;
    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_drive_reg;
    logic                out_load;

    logic [W-1:0]        mag_reg;
    logic                neg_reg;
    logic [F_W-1:0]      f_reg;
    logic                sh24_reg;
    logic [PW-1:0]       acc_reg;

    logic signed [W-1:0]  opnd_v;
    logic [F_W-1:0]       opnd_f;
    logic                 opnd_sh24;
    logic [HALF-1:0]      chunk;
    logic [HALF+F_W-1:0]  prod;
    logic [PW:0]          rnd_sum;
    logic [PW:0]          rnd_mag;
    logic signed [XW-1:0] rnd_x;
    logic signed [W-1:0]  rnd_val;
    logic signed [XW-1:0] diff_x;
    logic signed [XW-1:0] quo_x;

    logic                div_start;
    div_stat_t           div_stat;
    logic [W-1:0]        div_quo;

    pidf_div #(
        .W(W)
    ) u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (div_start),
        .dividend_mag (div_mag_reg),
        .divisor      (dt_reg),
        .stat         (div_stat),
        .quotient     (div_quo)
    );

    assign div_start = (state_reg == ST_POST) && (op_reg == OP_I);

    // Operand selection for the shared multiplier.
    always_comb begin
        case (op_reg)
            OP_P: begin
                opnd_v = err_reg;    opnd_f = F_W'(gain_p_reg); opnd_sh24 = 1'b0;
            end
            OP_INC: begin
                opnd_v = err_reg;    opnd_f = F_W'(dt_reg);     opnd_sh24 = 1'b1;
            end
            OP_I: begin
                opnd_v = accum_reg;  opnd_f = F_W'(gain_i_reg); opnd_sh24 = 1'b0;
            end
            OP_NEW: begin
                opnd_v = raw_reg;    opnd_f = F_W'(EMA_NEW);    opnd_sh24 = 1'b0;
            end
            OP_OLD: begin
                opnd_v = smooth_reg; opnd_f = F_W'(EMA_OLD);    opnd_sh24 = 1'b0;
            end
            OP_D: begin
                opnd_v = smooth_reg; opnd_f = F_W'(gain_d_reg); opnd_sh24 = 1'b0;
            end
            default: begin
                opnd_v = err_reg;    opnd_f = '0;               opnd_sh24 = 1'b0;
            end
        endcase
    end

    // The magnitude is multiplied in two halves on one multiplier.
    assign chunk = (state_reg == ST_MLO) ? mag_reg[HALF-1:0] : HALF'(mag_reg[W-1:HALF]);
    assign prod  = chunk * f_reg;

    // Round half away from zero on the magnitude, then restore the sign.
    always_comb begin
        rnd_sum = {1'b0, acc_reg} + (sh24_reg ? HALF24 : HALF16);
        rnd_mag = sh24_reg ? (rnd_sum >> 24) : (rnd_sum >> 16);
        rnd_x   = signed'(XW'(rnd_mag));
        rnd_val = sat_w(neg_reg ? -rnd_x : rnd_x);
    end

    assign diff_x = XW'(last_reg) - XW'(s_reg);
    assign quo_x  = signed'(XW'(div_quo));

    // The output register takes a new value when it is empty or its value leaves.
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_P;
            accum_reg       <= '0;
            last_reg        <= '0;
            smooth_reg      <= '0;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            drive_limit_reg <= '0;
            accum_limit_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_GAIN_P:      gain_p_reg      <= cfg_data;
                    CFG_GAIN_I:      gain_i_reg      <= cfg_data;
                    CFG_GAIN_D:      gain_d_reg      <= cfg_data;
                    CFG_DRIVE_LIMIT: drive_limit_reg <= cfg_data;
                    CFG_ACCUM_LIMIT: accum_limit_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        t_reg     <= sat_w(XW'(s_target));
                        s_reg     <= sat_w(XW'(s_sensed));
                        dt_reg    <= s_step_time;
                        hold_reg  <= s_hold_accum;
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    err_reg     <= sat_w(XW'(t_reg) - XW'(s_reg));
                    div_neg_reg <= diff_x[XW-1];
                    div_mag_reg <= diff_x[XW-1] ? (W+1)'(-diff_x) : (W+1)'(diff_x);
                    last_reg    <= s_reg;
                    op_reg      <= OP_P;
                    state_reg   <= ST_SEL;
                end
                ST_SEL: begin
                    mag_reg   <= opnd_v[W-1] ? W'(-opnd_v) : W'(opnd_v);
                    neg_reg   <= opnd_v[W-1];
                    f_reg     <= opnd_f;
                    sh24_reg  <= opnd_sh24;
                    state_reg <= ST_MLO;
                end
                ST_MLO: begin
                    acc_reg   <= PW'(prod);
                    state_reg <= ST_MHI;
                end
                ST_MHI: begin
                    acc_reg   <= acc_reg + (PW'(prod) << HALF);
                    state_reg <= ST_RND;
                end
                ST_RND: begin
                    r_reg     <= rnd_val;
                    state_reg <= ST_POST;
                end
                ST_POST: begin
                    case (op_reg)
                        OP_P: begin
                            p_reg     <= r_reg;
                            op_reg    <= hold_reg ? OP_I : OP_INC;
                            state_reg <= ST_SEL;
                        end
                        OP_INC: begin
                            accum_reg <= clamp_w(XW'(accum_reg) + XW'(r_reg), accum_limit_reg);
                            op_reg    <= OP_I;
                            state_reg <= ST_SEL;
                        end
                        OP_I: begin
                            sum_reg   <= XW'(p_reg) + XW'(r_reg);
                            state_reg <= ST_DIVW;
                        end
                        OP_NEW: begin
                            ema_reg   <= r_reg;
                            op_reg    <= OP_OLD;
                            state_reg <= ST_SEL;
                        end
                        OP_OLD: begin
                            smooth_reg <= sat_w(XW'(ema_reg) + XW'(r_reg));
                            op_reg     <= OP_D;
                            state_reg  <= ST_SEL;
                        end
                        OP_D: begin
                            drive_res_reg <= OUT_W'(XW'(clamp_w(sum_reg + XW'(r_reg),
                                                                drive_limit_reg)));
                            state_reg     <= ST_OUT;
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_DIVW: begin
                    if (div_stat.done) begin
                        if (div_stat.ovf) begin
                            raw_reg <= div_neg_reg ? WMIN_X[W-1:0] : WMAX_X[W-1:0];
                        end else begin
                            raw_reg <= sat_w(div_neg_reg ? -quo_x : quo_x);
                        end
                        op_reg    <= OP_NEW;
                        state_reg <= ST_SEL;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_drive_reg <= drive_res_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_drive   = signed'(m_drive_reg);

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import pidf_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int IDLE_MAX     = 11;
    localparam int SETTLE       = 8;
    localparam int END_QUIET    = 150;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 93;

    localparam logic signed [IN_W-1:0]  Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [IN_W-1:0]  Q_MIN = 32'sh8000_0000;
    localparam logic signed [IN_W-1:0]  ONE   = 32'sd65536;
    localparam logic signed [OUT_W-1:0] HALF  = 32'sd32768;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [GAIN_W-1:0] UNITY    = 31'd65536;
    localparam logic [DT_W-1:0]   DT_MAX   = '1;
    localparam logic [DT_W-1:0]   DT_HALF  = 24'h80_0000;
    localparam logic [DT_W-1:0]   DT_MS    = 24'h00_4189;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = CFG_ACCUM_LIMIT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

    localparam longint          V_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint          V_MIN   = -64'sh0000_0000_8000_0000;
    localparam longint unsigned MAG_TOP = 64'h4000_0000_0000_0000;

    typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [GAIN_W-1:0]       val;
        logic signed [IN_W-1:0]  tgt;
        logic signed [IN_W-1:0]  meas;
        logic [DT_W-1:0]         dt;
        logic                    hold;
        logic                    fixed;
        logic signed [OUT_W-1:0] want;
    } plan_row_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [GAIN_W-1:0]           cfg_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [IN_W-1:0]      s_target = '0;
    logic signed [IN_W-1:0]      s_sensed = '0;
    logic [DT_W-1:0]             s_step_time = '0;
    logic                        s_hold_accum = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [OUT_W-1:0]     m_drive;

    // Controller image: register copies and the three state words.
    longint unsigned kp = 0, ki = 0, kd = 0, out_lim = 0, int_lim = 0;
    longint          integ = 0, prev_meas = 0, rate_filt = 0;

    logic signed [OUT_W-1:0] drive_q [$];
    plan_row_t               plan [$];

    int     cycle_count = 0;
    int     fault_count = 0;
    int     n_checked = 0;
    int     n_samples = 0;
    int     n_held = 0;
    int     n_reg_writes = 0;
    int     gap_max = IDLE_MAX;
    int     stall_max = IDLE_MAX;
    logic   pending = 1'b0;

    pid_with_filtered_derivative_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_target     (s_target),
        .s_sensed     (s_sensed),
        .s_step_time  (s_step_time),
        .s_hold_accum (s_hold_accum),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive      (m_drive)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic longint clip(input longint x);
        if (x > V_MAX) return V_MAX;
        if (x < V_MIN) return V_MIN;
        return x;
    endfunction

    // Rounds v * f / 2^sh half away from zero, capping the magnitude at 2^62.
    function automatic longint scale_round(input longint v, input longint unsigned f,
                                           input int sh);
        logic            neg;
        longint unsigned m, hi, lo, r, h;
        neg = v < 0;
        m = neg ? 64'd0 - v : v;
        hi = m >> 32;
        lo = m & 64'hFFFF_FFFF;
        r = (lo * f + (64'd1 << (sh - 1))) >> sh;
        h = hi * f;
        if (h >= (64'd1 << (30 + sh))) r = MAG_TOP;
        else r = r + (h << (32 - sh));
        if (r > MAG_TOP) r = MAG_TOP;
        return clip(neg ? -longint'(r) : longint'(r));
    endfunction

    function automatic longint clamp_sym(input longint x, input longint unsigned lim);
        longint l;
        l = longint'(lim);
        if (x > l) x = l;
        else if (x < -l) x = -l;
        return clip(x);
    endfunction

    // Advances the controller image by one sample and returns its drive value.
    function automatic logic signed [OUT_W-1:0] next_drive(input logic signed [IN_W-1:0] tgt,
                                                          input logic signed [IN_W-1:0] meas,
                                                          input logic [DT_W-1:0] dt,
                                                          input logic hold);
        longint          t, s, err, p, it, dterm, raw, total;
        longint unsigned dv, m, q, qhi;
        logic            neg;
        t = tgt;
        s = meas;
        err = clip(t - s);
        p = scale_round(err, kp, 16);
        if (!hold) begin
            integ = clamp_sym(clip(integ + scale_round(err, dt, 24)), int_lim);
        end
        it = scale_round(integ, ki, 16);

        // Derivative on measurement; a zero time step divides by one.
        dv = (dt == 0) ? 64'd1 : 64'(dt);
        raw = prev_meas - s;
        neg = raw < 0;
        m = neg ? 64'd0 - raw : raw;
        qhi = m / dv;
        if (qhi >= (64'd1 << 38)) q = MAG_TOP;
        else q = (qhi << 24) + (((m % dv) << 24) / dv);
        if (q > MAG_TOP) q = MAG_TOP;
        raw = clip(neg ? -longint'(q) : longint'(q));
        prev_meas = s;

        rate_filt = clip(scale_round(raw, EMA_NEW, 16) + scale_round(rate_filt, EMA_OLD, 16));
        dterm = scale_round(rate_filt, kd, 16);
        total = clamp_sym(clip(p + it + dterm), out_lim);
        return total[OUT_W-1:0];
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [GAIN_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic plan_row_t smp_row(input logic signed [IN_W-1:0] tgt,
                                          input logic signed [IN_W-1:0] meas,
                                          input logic [DT_W-1:0] dt, input logic hold,
                                          input logic fixed, input logic signed [OUT_W-1:0] want);
        plan_row_t r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.tgt = tgt;
        r.meas = meas;
        r.dt = dt;
        r.hold = hold;
        r.fixed = fixed;
        r.want = want;
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_reg_value();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return GAIN_MAX;
            2: return GAIN_W'($urandom);
            3: return GAIN_W'($urandom_range(0, 1 << 20));
            default: return GAIN_W'($urandom_range(1 << 12, 1 << 19));
        endcase
    endfunction

    task automatic note_fault(input string what, input logic signed [OUT_W-1:0] want,
                              input logic signed [OUT_W-1:0] got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("result %0d, %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     n_checked, what, want, want, got, got);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_GAIN_P:      kp = val;
            CFG_GAIN_I:      ki = val;
            CFG_GAIN_D:      kd = val;
            CFG_DRIVE_LIMIT: out_lim = val;
            CFG_ACCUM_LIMIT: int_lim = val;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    // Lowers the configuration valid as well; writes never overlap a sample.
    task automatic send_sample(input logic signed [IN_W-1:0] tgt,
                               input logic signed [IN_W-1:0] meas,
                               input logic [DT_W-1:0] dt, input logic hold,
                               input logic fixed, input logic signed [OUT_W-1:0] want);
        int                      gap;
        logic signed [OUT_W-1:0] predicted;
        gap = $urandom_range(0, gap_max);
        cfg_valid <= 1'b0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_target <= tgt;
        s_sensed <= meas;
        s_step_time <= dt;
        s_hold_accum <= hold;
        do @(posedge aclk); while (!s_ready);
        predicted = next_drive(tgt, meas, dt, hold);
        drive_q.push_back(fixed ? want : predicted);
        pending = 1'b1;
        n_samples++;
        if (hold) n_held++;
    endtask

    // Always advances the clock before returning, so valid is never lowered and raised in one step.
    task automatic wait_idle(input int settle);
        s_valid <= 1'b0;
        do @(posedge aclk); while (drive_q.size() != 0);
        repeat (settle) @(posedge aclk);
        pending = 1'b0;
    endtask

    initial begin : drive_monitor
        int                      stall;
        logic signed [OUT_W-1:0] want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            n_checked++;
            if (drive_q.size() == 0) begin
                note_fault("drive with no sample pending", 'x, m_drive);
            end else begin
                want = drive_q.pop_front();
                if (m_drive !== want) note_fault("drive", want, m_drive);
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, drive_q.size());
        $display("pid_with_filtered_derivative_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        int                     i, phase, k, setpoint, walk, nominal, n_directed;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic signed [IN_W-1:0] tgt, meas;
        logic [DT_W-1:0]        dt;
        logic                   hold;

        // Rows with a typed result are the ones readable by hand: reset registers,
        // pure proportional at the extremes, zero limits and exact integral steps.
        plan = '{
            smp_row(Q_MAX, Q_MIN, DT_MAX, 1'b0, 1'b1, '0),
            smp_row(Q_MIN, Q_MAX, 24'd1, 1'b1, 1'b1, '0),
            smp_row('0, '0, '0, 1'b0, 1'b1, '0),
            reg_row(CFG_GAIN_P, UNITY),
            reg_row(CFG_DRIVE_LIMIT, GAIN_MAX),
            reg_row(CFG_ACCUM_LIMIT, GAIN_MAX),
            smp_row(5 * ONE, 2 * ONE, 24'h10_0000, 1'b0, 1'b1, 3 * ONE),
            smp_row(Q_MAX, Q_MIN, DT_MAX, 1'b0, 1'b1, Q_MAX),
            smp_row(Q_MIN, Q_MAX, 24'd1, 1'b0, 1'b1, -Q_MAX),
            smp_row('0, '0, DT_MAX, 1'b1, 1'b1, '0),
            reg_row(CFG_GAIN_P, '0),
            reg_row(CFG_GAIN_I, UNITY),
            reg_row(CFG_ACCUM_LIMIT, '0),
            smp_row(Q_MAX, Q_MIN, DT_MAX, 1'b0, 1'b1, '0),
            reg_row(CFG_ACCUM_LIMIT, GAIN_MAX),
            smp_row(ONE, '0, DT_HALF, 1'b0, 1'b1, HALF),
            smp_row(ONE, '0, DT_HALF, 1'b1, 1'b1, HALF),
            smp_row(ONE, '0, '0, 1'b0, 1'b1, HALF),
            smp_row(ONE, '0, DT_HALF, 1'b0, 1'b1, ONE),
            reg_row(CFG_GAIN_I, '0),
            reg_row(CFG_GAIN_D, UNITY),
            reg_row(CFG_GAIN_P, GAIN_MAX),
            smp_row('0, ONE, DT_MAX, 1'b0, 1'b0, '0),
            smp_row('0, -5 * ONE, 24'd1, 1'b1, 1'b0, '0),
            smp_row(Q_MIN, Q_MAX, DT_MAX, 1'b0, 1'b0, '0),
            smp_row(ONE, Q_MIN, '0, 1'b0, 1'b0, '0),
            reg_row(CFG_GAIN_I, GAIN_MAX),
            reg_row(CFG_GAIN_D, GAIN_MAX),
            reg_row(CFG_DRIVE_LIMIT, '0),
            smp_row(Q_MAX, Q_MIN, DT_MAX, 1'b0, 1'b1, '0),
            reg_row(CFG_DRIVE_LIMIT, UNITY),
            smp_row('0, '0, DT_MS, 1'b0, 1'b0, '0),
            smp_row(Q_MIN, Q_MAX, 24'd1, 1'b1, 1'b0, '0),
            reg_row(CFG_SPARE, GAIN_MAX),
            smp_row(-3 * ONE, ONE, DT_MS, 1'b0, 1'b0, '0)
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < plan.size(); i++) begin
            if (plan[i].kind == ROW_REG) begin
                if (pending) wait_idle(SETTLE);
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_sample(plan[i].tgt, plan[i].meas, plan[i].dt, plan[i].hold,
                            plan[i].fixed, plan[i].want);
            end
        end
        n_directed = n_samples;

        // Each phase holds one register setting and mostly tracks a setpoint with a
        // drifting measurement; about a quarter of the samples are raw noise.
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            wait_idle(SETTLE);
            for (reg_idx = CFG_GAIN_P; reg_idx <= CFG_ACCUM_LIMIT; reg_idx++) begin
                write_reg(reg_idx, pick_reg_value());
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE, CFG_IDX_TOP)),
                          GAIN_W'($urandom));
            end
            gap_max = (phase % 3 == 1) ? 0 : IDLE_MAX;
            stall_max = (phase % 4 == 2) ? 0 : IDLE_MAX;
            setpoint = int'($urandom_range(0, 40 * ONE)) - 20 * ONE;
            walk = setpoint + int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
            nominal = $urandom_range(100, 300000);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 3) != 0) begin
                    walk = walk + int'($urandom_range(0, 2 * ONE)) - ONE;
                    tgt = setpoint + int'($urandom_range(0, 1023)) - 512;
                    meas = walk;
                    dt = DT_W'(nominal + $urandom_range(0, nominal / 8));
                    hold = ($urandom_range(0, 9) == 0);
                end else begin
                    tgt = $urandom;
                    meas = $urandom;
                    dt = DT_W'($urandom);
                    hold = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 7))
                        0: tgt = Q_MAX;
                        1: tgt = Q_MIN;
                        2: meas = Q_MAX;
                        3: meas = Q_MIN;
                        4: dt = '0;
                        5: dt = DT_MAX;
                        default: ;
                    endcase
                end
                send_sample(tgt, meas, dt, hold, 1'b0, '0);
                if ($urandom_range(0, 49) == 0) wait_idle(0);
            end
        end

        wait_idle(END_QUIET);

        $display("Ran %0d samples (%0d directed, %0d with the integral frozen) through %0d register writes.",
                 n_samples, n_directed, n_held, n_reg_writes);
        $display("Checked %0d drive values; %0d did not agree with the predicted controller.",
                 n_checked, fault_count);
        if (fault_count == 0 && drive_q.size() == 0) begin
            $display("pid_with_filtered_derivative_core: match");
        end else begin
            $display("pid_with_filtered_derivative_core: mismatch");
        end
        $finish;
    end

endmodule
